/* rtl/key_value_table_assert.svh */
// Assertion macros for the key/value table.
// Used by the top level only; no other dependencies.
`ifndef KEY_VALUE_TABLE_ASSERT_SVH
`define KEY_VALUE_TABLE_ASSERT_SVH

// same-cycle implication
`define KVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key_value_table: implication check failed");

// next-cycle implication
`define KVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key_value_table: next-cycle check failed");

`endif

/* rtl/kvt_pkg.sv */
// Shared types and constants for the key/value table.
// No dependencies.
package kvt_pkg;

  localparam int FIELD_W   = 32;
  localparam int OP_W      = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic                 ok;
    logic [FIELD_W-1:0]   found_value;
    logic                 full_res;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 is_empty;
  } kvt_res_t;

  typedef struct packed {
    logic rd_en;
    logic we_kv;
    logic we_vld;
    logic wvld;
  } kvt_mem_ctl_t;

endpackage

/* rtl/kvt_if.sv */
// Valid/ready channel interfaces for request and result items.
// Depends on kvt_pkg for field widths.
interface kvt_in_if;
  import kvt_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [FIELD_W-1:0] key;
  logic [FIELD_W-1:0] value;
  modport source (output valid, operation, key, value, input ready);
  modport sink (input valid, operation, key, value, output ready);
endinterface

interface kvt_out_if;
  import kvt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [FIELD_W-1:0]   found_value;
  logic                 full_res;
  logic [CNT_OUT_W-1:0] entry_count;
  logic                 is_empty;
  modport source (output valid, ok, found_value, full_res, entry_count, is_empty,
                  input ready);
  modport sink (input valid, ok, found_value, full_res, entry_count, is_empty,
                output ready);
endinterface

/* rtl/kvt_store.sv */
// Slot memories: keys, values and valid marks, one shared port.
// Depends on kvt_pkg for the control struct.
module kvt_store #(
  parameter int CAPACITY = 16,
  parameter int KW       = 32,
  parameter int VW       = 32
) (
  input  logic                        clk,
  input  kvt_pkg::kvt_mem_ctl_t       ctl,
  input  logic [$clog2(CAPACITY)-1:0] addr,
  input  logic [KW-1:0]               wkey,
  input  logic [VW-1:0]               wval,
  output logic [KW-1:0]               q_key,
  output logic [VW-1:0]               q_val,
  output logic                        q_vld
);
  import kvt_pkg::*;

  logic [KW-1:0] key_mem [CAPACITY];
  logic [VW-1:0] val_mem [CAPACITY];
  logic          vld_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (ctl.we_kv) begin
      key_mem[addr] <= wkey;
      val_mem[addr] <= wval;
    end
    if (ctl.we_vld) begin
      vld_mem[addr] <= ctl.wvld;
    end
    if (ctl.rd_en) begin
      q_key <= key_mem[addr];
      q_val <= val_mem[addr];
      q_vld <= vld_mem[addr];
    end
  end

endmodule

/* rtl/kvt_ctrl.sv */
// Sequencer: clearing pass, slot scan through one comparator, write-back.
// Depends on kvt_pkg; drives kvt_store.
module kvt_ctrl #(
  parameter int CAPACITY = 16,
  parameter int KW       = 32,
  parameter int VW       = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [kvt_pkg::OP_W-1:0]      op,
  input  logic [KW-1:0]                 key,
  input  logic [VW-1:0]                 value,
  output logic                          idle,
  input  logic                          out_free,
  output logic                          res_load,
  output kvt_pkg::kvt_res_t             res,
  output kvt_pkg::kvt_mem_ctl_t         mem_ctl,
  output logic [$clog2(CAPACITY)-1:0]   mem_addr,
  output logic [KW-1:0]                 mem_wkey,
  output logic [VW-1:0]                 mem_wval,
  input  logic [KW-1:0]                 q_key,
  input  logic [VW-1:0]                 q_val,
  input  logic                          q_vld
);
  import kvt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_TAIL  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [OP_W-1:0] op_r;
  logic [KW-1:0]   key_r;
  logic [VW-1:0]   val_r;
  logic            rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]   rd_idx_r;
  logic            hit_r, hit_nxt;
  logic [AW-1:0]   hit_idx_r;
  logic [VW-1:0]   hit_val_r;
  logic            free_r, free_nxt;
  logic [AW-1:0]   free_idx_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  logic key_match, slot_free, is_full, do_add, do_rem;

  // shared comparator on the registered read data
  assign key_match = rd_vld_r && q_vld && (q_key == key_r);
  assign slot_free = rd_vld_r && !q_vld;

  assign is_full = (cnt_r >= CAP_CNT);
  assign do_add  = (op_r == OP_ADD) && !hit_r && !is_full;
  assign do_rem  = (op_r == OP_REMOVE) && hit_r;

  assign idle     = (state_r == ST_IDLE);
  assign mem_wkey = key_r;
  assign mem_wval = val_r;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = 1'b0;
    hit_nxt    = hit_r;
    free_nxt   = free_r;
    cnt_nxt    = cnt_r;
    mem_ctl    = '0;
    mem_addr   = idx_r;
    res_load   = 1'b0;
    res        = '0;

    if (key_match) begin
      hit_nxt = 1'b1;
    end
    if (slot_free) begin
      free_nxt = 1'b1;
    end

    unique case (state_r)
      ST_CLR: begin
        mem_ctl.we_vld = 1'b1;
        mem_ctl.wvld   = 1'b0;
        idx_nxt        = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        mem_ctl.rd_en = 1'b1;
        rd_vld_nxt    = 1'b1;
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (do_add) begin
            mem_ctl.we_kv  = 1'b1;
            mem_ctl.we_vld = 1'b1;
            mem_ctl.wvld   = 1'b1;
            mem_addr       = free_idx_r;
            cnt_nxt        = cnt_r + 1'b1;
          end else if (do_rem) begin
            mem_ctl.we_vld = 1'b1;
            mem_ctl.wvld   = 1'b0;
            mem_addr       = hit_idx_r;
            cnt_nxt        = cnt_r - 1'b1;
          end
        end
        res.ok          = do_add || do_rem || ((op_r == OP_LOOKUP) && hit_r);
        res.found_value = ((op_r == OP_LOOKUP) && hit_r) ? FIELD_W'(hit_val_r) : '0;
        res.full_res    = (op_r == OP_ADD) && !hit_r && is_full;
        res.entry_count = CNT_OUT_W'(cnt_nxt);
        res.is_empty    = (cnt_nxt == '0);
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= rd_vld_nxt;
      hit_r    <= hit_nxt;
      free_r   <= free_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    if (idle && start) begin
      op_r  <= op;
      key_r <= key;
      val_r <= value;
    end
    if (key_match && !hit_r) begin
      hit_idx_r <= rd_idx_r;
      hit_val_r <= q_val;
    end
    if (slot_free && !free_r) begin
      free_idx_r <= rd_idx_r;
    end
  end

endmodule

/* rtl/key_value_table.sv */
// key_value_table: fixed-capacity key/value table with unique keys.
// Depends on kvt_pkg, kvt_if, kvt_store, kvt_ctrl and the assertion header.
//
// Usage:
//   in_ch carries one request item: operation (add, look up, remove), key
//   and value. out_ch returns one result item per request: ok, found_value,
//   full_res, entry_count and is_empty after the operation.
//   Each request scans every slot through the single port of the slot
//   memory, one slot a cycle, and one comparator checks the key against
//   each. An accepted item passes the scan, a tail state and write-back,
//   after which the result is registered; the next item is accepted only
//   once the write-back is done, so one item is handled at a time.
//   After reset a clearing pass marks every slot free; in_ch.ready
//   stays low during it.
//   The result sits in an output register. A new request is accepted while
//   it waits; if the receiver still stalls when the next result is ready,
//   the block holds in write-back until the register frees.
//   Keys and values are held to their low KEY_BITS and VALUE_BITS bits.
module key_value_table #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input logic      clk,
  input logic      rst_n,
  kvt_in_if.sink   in_ch,
  kvt_out_if.source out_ch
);
  import kvt_pkg::*;
  `include "key_value_table_assert.svh"

  localparam int KW = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
  localparam int VW = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int AW = $clog2(CAPACITY);

  logic          ctrl_idle, out_free, res_load, in_acc;
  kvt_res_t      res, out_r;
  logic          out_valid_r;
  kvt_mem_ctl_t  mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [KW-1:0] mem_wkey, q_key;
  logic [VW-1:0] mem_wval, q_val;
  logic          q_vld;

  assign in_ch.ready = ctrl_idle;
  assign in_acc      = in_ch.valid && ctrl_idle;
  assign out_free    = !out_valid_r || out_ch.ready;

  kvt_ctrl #(
    .CAPACITY (CAPACITY),
    .KW       (KW),
    .VW       (VW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .op       (in_ch.operation),
    .key      (in_ch.key[KW-1:0]),
    .value    (in_ch.value[VW-1:0]),
    .idle     (ctrl_idle),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .mem_ctl  (mem_ctl),
    .mem_addr (mem_addr),
    .mem_wkey (mem_wkey),
    .mem_wval (mem_wval),
    .q_key    (q_key),
    .q_val    (q_val),
    .q_vld    (q_vld)
  );

  kvt_store #(
    .CAPACITY (CAPACITY),
    .KW       (KW),
    .VW       (VW)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wkey  (mem_wkey),
    .wval  (mem_wval),
    .q_key (q_key),
    .q_val (q_val),
    .q_vld (q_vld)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_r.ok;
  assign out_ch.found_value = out_r.found_value;
  assign out_ch.full_res    = out_r.full_res;
  assign out_ch.entry_count = out_r.entry_count;
  assign out_ch.is_empty    = out_r.is_empty;

  `KVT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ch.ready)
  `KVT_ASSERT_IMP(a_load_only_when_free, clk, rst_n, res_load, out_free)
  `KVT_ASSERT_IMP(a_ok_excludes_full, clk, rst_n, out_valid_r, !(out_r.ok && out_r.full_res))

endmodule
